// ===== design/kdgt_pkg.sv =====
`default_nettype none
package kdgt_pkg;

	localparam int NUM_KEYS    = 16;
	localparam int TICK_LIMIT  = 65535;
	localparam int COUNT_LIMIT = 255;
	localparam int QUEUE_DEPTH = 2;

	localparam int KEY_W      = 4;
	localparam int KEY_SEL_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CNT_W      = 16;
	localparam int TALLY_W    = 8;
	localparam int EV_W       = 8;
	localparam int SIG_W      = 3;
	localparam int GST_W      = 2;
	localparam int FL_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [KEY_W:0]     KEY_COUNT = (KEY_W + 1)'(NUM_KEYS);
	localparam logic [CNT_W-1:0]   TICK_MAX  = CNT_W'(TICK_LIMIT);
	localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(COUNT_LIMIT);

	localparam logic [CFG_IDX_W-1:0] REG_PRESS_DB      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DB    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_PRESS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_RELEASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_MODE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MODE  = 3'd6;

	localparam logic [SIG_W-1:0] SIG_IDLE     = 3'd0;
	localparam logic [SIG_W-1:0] SIG_PDB      = 3'd1;
	localparam logic [SIG_W-1:0] SIG_PRESSED  = 3'd2;
	localparam logic [SIG_W-1:0] SIG_RDB      = 3'd3;
	localparam logic [SIG_W-1:0] SIG_RELEASED = 3'd4;

	localparam logic [GST_W-1:0] GST_IDLE     = 2'd0;
	localparam logic [GST_W-1:0] GST_PRESSED  = 2'd1;
	localparam logic [GST_W-1:0] GST_RELEASED = 2'd2;

	localparam int FL_LONG  = 0;
	localparam int FL_MULTI = 1;

	localparam logic [EV_W-1:0] EV_PRESS_EAGER = 8'h01;
	localparam logic [EV_W-1:0] EV_PRESS_DEFER = 8'h02;
	localparam logic [EV_W-1:0] EV_REL_EAGER   = 8'h04;
	localparam logic [EV_W-1:0] EV_REL_DEFER   = 8'h08;
	localparam logic [EV_W-1:0] EV_LONG_PRESS  = 8'h10;
	localparam logic [EV_W-1:0] EV_LONG_REL    = 8'h20;
	localparam logic [EV_W-1:0] EV_MP_TIMEOUT  = 8'h40;
	localparam logic [EV_W-1:0] EV_MR_TIMEOUT  = 8'h80;

	typedef struct packed {
		logic [CNT_W-1:0] press_db;
		logic [CNT_W-1:0] release_db;
		logic [CNT_W-1:0] long_press;
		logic [CNT_W-1:0] multi_press_to;
		logic [CNT_W-1:0] multi_release_to;
		logic             press_deferred;
		logic             release_deferred;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             low;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage
`default_nettype wire

// ===== design/kdgt_in_if.sv =====
`default_nettype none
interface kdgt_in_if import kdgt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_index;
	logic             key_level;

	modport source (output valid, output key_index, output key_level, input ready);
	modport sink (input valid, input key_index, input key_level, output ready);
endinterface
`default_nettype wire

// ===== design/kdgt_out_if.sv =====
`default_nettype none
interface kdgt_out_if import kdgt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KEY_W-1:0]   key_id;
	logic [EV_W-1:0]    event_bits;
	logic [TALLY_W-1:0] press_tally;

	modport source (output valid, output key_id, output event_bits, output press_tally,
		input ready);
	modport sink (input valid, input key_id, input event_bits, input press_tally,
		output ready);
endinterface
`default_nettype wire

// ===== design/kdgt_cfg_if.sv =====
`default_nettype none
interface kdgt_cfg_if import kdgt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/kdgt_front.sv =====
`default_nettype none
module kdgt_front import kdgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kdgt_in_if.sink    key_in,
	kdgt_cfg_if.sink   cfg,
	input  fifo_stat_t stat,
	output logic       push,
	output item_t      push_item,
	output cfg_t       cfg_q
);

	assign key_in.ready   = !stat.full;
	assign cfg.ready      = 1'b1;
	assign push_item.key  = key_in.key_index;
	assign push_item.low  = !key_in.key_level;

	// drop requests for keys beyond the store
	assign push = key_in.valid && key_in.ready
		&& ((KEY_W + 1)'(key_in.key_index) < KEY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_db         <= CNT_W'(2);
			cfg_q.release_db       <= CNT_W'(2);
			cfg_q.long_press       <= CNT_W'(100);
			cfg_q.multi_press_to   <= CNT_W'(30);
			cfg_q.multi_release_to <= CNT_W'(30);
			cfg_q.press_deferred   <= 1'b1;
			cfg_q.release_deferred <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PRESS_DB:      cfg_q.press_db         <= cfg.data;
				REG_RELEASE_DB:    cfg_q.release_db       <= cfg.data;
				REG_LONG_PRESS:    cfg_q.long_press       <= cfg.data;
				REG_MULTI_PRESS:   cfg_q.multi_press_to   <= cfg.data;
				REG_MULTI_RELEASE: cfg_q.multi_release_to <= cfg.data;
				REG_PRESS_MODE:    cfg_q.press_deferred   <= cfg.data[0];
				REG_RELEASE_MODE:  cfg_q.release_deferred <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/kdgt_fifo.sv =====
`default_nettype none
module kdgt_fifo import kdgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  item_t      push_item,
	input  logic       pop,
	output item_t      head,
	output fifo_stat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_Q_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_Q_W-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_Q_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_Q_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_Q_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/kdgt_back.sv =====
`default_nettype none
module kdgt_back import kdgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_q,
	input  item_t      head,
	input  fifo_stat_t stat,
	output logic       pop,
	kdgt_out_if.source event_out
);

	logic [SIG_W-1:0]   sig_q   [NUM_KEYS];
	logic [GST_W-1:0]   gst_q   [NUM_KEYS];
	logic [FL_W-1:0]    flags_q [NUM_KEYS];
	logic [CNT_W-1:0]   tick_q  [NUM_KEYS];
	logic [TALLY_W-1:0] tally_q [NUM_KEYS];

	logic               out_valid_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [EV_W-1:0]    out_ev_q;
	logic [TALLY_W-1:0] out_tally_q;

	logic [KEY_SEL_W-1:0] sel;
	logic [SIG_W-1:0]     sig_n;
	logic [GST_W-1:0]     gst_n;
	logic [FL_W-1:0]      flags_n;
	logic [CNT_W-1:0]     tick_n;
	logic [TALLY_W-1:0]   tally_n;
	logic [EV_W-1:0]      ev_n;

	assign sel = head.key[KEY_SEL_W-1:0];
	assign pop = !stat.empty && (!out_valid_q || event_out.ready);

	always_comb begin
		logic [SIG_W-1:0]   sp;
		logic [CNT_W-1:0]   t;
		logic [CNT_W-1:0]   t_inc;
		logic [CNT_W-1:0]   t_sat;
		logic               low;
		logic               press_hit;
		logic               rel_hit;
		sp      = sig_q[sel];
		t       = tick_q[sel];
		low     = head.low;
		t_inc   = t + CNT_W'(1);
		t_sat   = (t < TICK_MAX) ? t_inc : t;
		sig_n   = sp;
		gst_n   = gst_q[sel];
		flags_n = flags_q[sel];
		tick_n  = t;
		tally_n = tally_q[sel];
		ev_n    = '0;

		// debounce chain, the tick that enters a debounce, pressed or released phase counts as its first
		case (sp)
			SIG_IDLE, SIG_RELEASED: begin
				if (low) begin
					ev_n   = EV_PRESS_EAGER;
					tick_n = CNT_W'(1);
					if (sp == SIG_RELEASED) begin
						gst_n = GST_IDLE;
					end
					if (cfg_q.press_db == '0) begin
						sig_n = SIG_PRESSED;
						ev_n  = ev_n | EV_PRESS_DEFER;
					end else begin
						sig_n = SIG_PDB;
					end
				end else if (sp == SIG_RELEASED) begin
					tick_n = t_sat;
				end
			end
			SIG_PDB: begin
				if (t >= cfg_q.press_db) begin
					if (low) begin
						sig_n  = SIG_PRESSED;
						ev_n   = EV_PRESS_DEFER;
						tick_n = CNT_W'(1);
					end else begin
						sig_n   = SIG_IDLE;
						gst_n   = GST_IDLE;
						flags_n = '0;
					end
				end else begin
					tick_n = t_inc;
				end
			end
			SIG_PRESSED: begin
				if (!low) begin
					ev_n   = EV_REL_EAGER;
					tick_n = CNT_W'(1);
					if (cfg_q.release_db == '0) begin
						sig_n = SIG_RELEASED;
						ev_n  = ev_n | EV_REL_DEFER;
					end else begin
						sig_n = SIG_RDB;
					end
				end else begin
					tick_n = t_sat;
				end
			end
			SIG_RDB: begin
				if (t >= cfg_q.release_db) begin
					if (!low) begin
						sig_n  = SIG_RELEASED;
						ev_n   = EV_REL_DEFER;
						tick_n = CNT_W'(1);
					end else begin
						sig_n   = SIG_IDLE;
						gst_n   = GST_IDLE;
						flags_n = '0;
					end
				end else begin
					tick_n = t_inc;
				end
			end
			default: ;
		endcase

		press_hit = |(ev_n & (cfg_q.press_deferred ? EV_PRESS_DEFER : EV_PRESS_EAGER));
		rel_hit   = |(ev_n & (cfg_q.release_deferred ? EV_REL_DEFER : EV_REL_EAGER));

		// gesture chain: idle, pressed and released fall through in order
		if (gst_n == GST_IDLE && press_hit) begin
			gst_n = GST_PRESSED;
			if (flags_n[FL_MULTI]) begin
				if (tally_n < TALLY_MAX) begin
					tally_n = tally_n + TALLY_W'(1);
				end
			end else begin
				tally_n           = TALLY_W'(1);
				flags_n[FL_MULTI] = 1'b1;
			end
		end
		if (gst_n == GST_PRESSED) begin
			if (rel_hit) begin
				gst_n = GST_RELEASED;
			end else begin
				if (!flags_n[FL_LONG] && tick_n > cfg_q.long_press) begin
					flags_n[FL_LONG] = 1'b1;
					ev_n             = ev_n | EV_LONG_PRESS;
				end
				if (flags_n[FL_MULTI] && tick_n > cfg_q.multi_press_to) begin
					flags_n[FL_MULTI] = 1'b0;
					ev_n              = ev_n | EV_MP_TIMEOUT;
				end
			end
		end
		if (gst_n == GST_RELEASED) begin
			if (flags_n[FL_LONG]) begin
				flags_n[FL_LONG] = 1'b0;
				ev_n             = ev_n | EV_LONG_REL;
			end
			if (flags_n[FL_MULTI]) begin
				if (tick_n > cfg_q.multi_release_to) begin
					flags_n[FL_MULTI] = 1'b0;
					ev_n              = ev_n | EV_MR_TIMEOUT;
				end
			end else if (sig_n == SIG_RELEASED) begin
				sig_n   = SIG_IDLE;
				gst_n   = GST_IDLE;
				flags_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				sig_q[k]   <= SIG_IDLE;
				gst_q[k]   <= GST_IDLE;
				flags_q[k] <= '0;
				tick_q[k]  <= '0;
				tally_q[k] <= '0;
			end
		end else if (pop) begin
			sig_q[sel]   <= sig_n;
			gst_q[sel]   <= gst_n;
			flags_q[sel] <= flags_n;
			tick_q[sel]  <= tick_n;
			tally_q[sel] <= tally_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && ev_n != '0) begin
			out_valid_q <= 1'b1;
		end else if (event_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && ev_n != '0) begin
			out_key_q   <= head.key;
			out_ev_q    <= ev_n;
			out_tally_q <= tally_n;
		end
	end

	assign event_out.valid       = out_valid_q;
	assign event_out.key_id      = out_key_q;
	assign event_out.event_bits  = out_ev_q;
	assign event_out.press_tally = out_tally_q;

endmodule
`default_nettype wire

// ===== design/key_debounce_gesture_tracker.sv =====
// Key debounce and gesture tracker.
// key_in carries one scan tick request per transfer: key_index and the active-low
// key_level. event_out carries one request per tick that raises any event: key_id,
// event_bits and the key's press_tally. cfg writes the seven settings by index;
// it is always ready; it is to be written only while the block is idle, a duty of the user.
// A tick request enters a two-entry queue at the accepting edge. The back end pops
// it, reads the key's state, runs the debounce and gesture chains and writes the
// state back as it pops it, loading the output register at the same edge: a result
// goes from the queue entry to the output register when nothing waits.
// One tick per cycle is sustained while the receiver takes each request; the per-key
// state is read and written back at each pop. Ticks that raise no event produce
// no request. While the receiver stalls, the output register holds its request,
// the queue fills and key_in.ready drops once both entries are taken.
// Reset clears every key's phases, flags and counters and restores the settings
// to their defaults; key_in.ready is high as soon as reset is released.
`default_nettype none
module key_debounce_gesture_tracker import kdgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kdgt_in_if.sink    key_in,
	kdgt_cfg_if.sink   cfg,
	kdgt_out_if.source event_out
);

	cfg_t       cfg_q;
	fifo_stat_t stat;
	item_t      push_item;
	item_t      head;
	logic       push;
	logic       pop;

	kdgt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (key_in),
		.cfg       (cfg),
		.stat      (stat),
		.push      (push),
		.push_item (push_item),
		.cfg_q     (cfg_q)
	);

	kdgt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	kdgt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_q     (cfg_q),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.event_out (event_out)
	);

	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		event_out.valid |-> event_out.event_bits != '0)
		else $error("result request without events");

	a_press_release_apart: assert property (@(posedge clk) disable iff (!arst_n)
		event_out.valid |-> !((event_out.event_bits[0] || event_out.event_bits[1])
			&& (event_out.event_bits[2] || event_out.event_bits[3])))
		else $error("press and release events in one tick");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire
